// ----- rtl/pom_pkg.sv -----
// Shared types and codes for the priority-ordered member list.
// Used by pom_cell, the core top level and the checker; depends on nothing.
package pom_pkg;

    localparam int CMD_W    = 3;
    localparam int ID_FW    = 12;
    localparam int KEY_W    = 16;
    localparam int POS_FW   = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_FW = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_FW-1:0]  actor_id;
        logic [KEY_W-1:0]  priority_key;
        logic              has_key;
        logic [POS_FW-1:0] position;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_FW-1:0]   found_position;
        logic [ID_FW-1:0]    read_id;
        logic [COUNT_FW-1:0] member_count;
        logic                head_valid;
        logic [ID_FW-1:0]    head_id;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD      = 2'd0,
        OP_LOAD      = 2'd1,
        OP_FROM_PREV = 2'd2,
        OP_FROM_NEXT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     capture;
    } t_cell_ctrl;

    typedef struct packed {
        logic match;
        logic higher;
    } t_cell_flags;

endpackage

// ----- rtl/priority_ordered_member_list_core.sv -----
// Priority-ordered member list: top level with the row of pom_cell slots,
// the sequencer and the result register. Depends on pom_pkg and pom_cell.
//
// The block keeps up to DEPTH member ids in order. Every command passes
// through a compare step and an update step: in the cycle of the input
// transfer each cell compares its stored id and key with the command and
// registers the outcome; in the update state that follows, the first
// matching or first lower-keyed slot is picked out by a ripple across the
// row of cells, the row shifts by one place (open a gap for an insert,
// close one for a remove) and the result is loaded into the output register.
// No new command is taken until that update is done. The update waits while
// an earlier result is still unclaimed at the output. One command can be
// accepted while a result waits; the one after it is held off until that
// command's update is done. member_count, head_valid and head_id show the list
// as it stands after the command whose result is presented. Slot contents need
// no clearing after reset: only slots below the fill count are ever read.
module priority_ordered_member_list_core #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pom_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pom_pkg::t_out_item o_out_data
);
    import pom_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > POS_FW) ? CNT_W : POS_FW;
    localparam int ID_TAKE = (ID_BITS < ID_FW) ? ID_BITS : ID_FW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    t_in_item            r_cmd;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [POS_FW-1:0]   r_found,  n_found;
    logic [ID_FW-1:0]    r_rid,    n_rid;

    logic in_xfer;
    logic do_upd;

    // command bus: the incoming item while comparing, the held one while updating
    t_in_item           bus;
    logic [ID_BITS-1:0] bus_id;

    t_cell_ctrl         cell_ctrl  [DEPTH];
    t_cell_flags        cell_flags [DEPTH];
    logic [ID_BITS-1:0] cell_id    [DEPTH];
    logic [KEY_W-1:0]   cell_key   [DEPTH];
    logic               cell_keyed [DEPTH];

    logic [DEPTH-1:0] occ, hit, hig;
    logic [DEPTH:0]   seen_hit, seen_hig;
    logic [DEPTH-1:0] first_hit, first_hig;
    logic [IDX_W-1:0] hit_pos, hig_pos;
    logic [ID_BITS-1:0] read_sel;

    logic [CMP_W-1:0] pos_w, cnt_w;
    logic             full;
    logic             do_ins, do_rem;
    logic [CNT_W-1:0] ins_pos;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = r_state == S_IDLE;
    assign do_upd     = (r_state == S_UPD) && (!r_out_valid || i_out_ready);

    assign bus    = (r_state == S_IDLE) ? i_in_data : r_cmd;
    assign bus_id = ID_BITS'(bus.actor_id[ID_TAKE-1:0]);

    // row of slots, each handing its entry to both neighbours
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0] prev_id,  next_id;
        logic [KEY_W-1:0]   prev_key, next_key;
        logic               prev_keyed, next_keyed;

        if (g == 0) begin : g_first
            assign prev_id    = bus_id;
            assign prev_key   = bus.priority_key;
            assign prev_keyed = bus.has_key;
        end else begin : g_mid_prev
            assign prev_id    = cell_id[g-1];
            assign prev_key   = cell_key[g-1];
            assign prev_keyed = cell_keyed[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_id    = cell_id[g];
            assign next_key   = cell_key[g];
            assign next_keyed = cell_keyed[g];
        end else begin : g_mid_next
            assign next_id    = cell_id[g+1];
            assign next_key   = cell_key[g+1];
            assign next_keyed = cell_keyed[g+1];
        end

        pom_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl[g]),
            .i_bus_id     (bus_id),
            .i_bus_key    (bus.priority_key),
            .i_bus_keyed  (bus.has_key),
            .i_prev_id    (prev_id),
            .i_prev_key   (prev_key),
            .i_prev_keyed (prev_keyed),
            .i_next_id    (next_id),
            .i_next_key   (next_key),
            .i_next_keyed (next_keyed),
            .o_id         (cell_id[g]),
            .o_key        (cell_key[g]),
            .o_keyed      (cell_keyed[g]),
            .o_flags      (cell_flags[g])
        );

        assign occ[g] = CNT_W'(g) < r_count;
        assign hit[g] = cell_flags[g].match  && occ[g];
        assign hig[g] = cell_flags[g].higher && occ[g];

        // ripple the "already seen" marks along the row to keep the first one
        assign seen_hit[g+1] = seen_hit[g] | hit[g];
        assign seen_hig[g+1] = seen_hig[g] | hig[g];
        assign first_hit[g]  = hit[g] && !seen_hit[g];
        assign first_hig[g]  = hig[g] && !seen_hig[g];
    end

    assign seen_hit[0] = 1'b0;
    assign seen_hig[0] = 1'b0;

    // encode the one-hot first positions and select the read-at slot
    always_comb begin
        hit_pos  = '0;
        hig_pos  = '0;
        read_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) begin
                hit_pos = hit_pos | IDX_W'(i);
            end
            if (first_hig[i]) begin
                hig_pos = hig_pos | IDX_W'(i);
            end
            if (CMP_W'(i) == pos_w) begin
                read_sel = read_sel | cell_id[i];
            end
        end
    end

    assign pos_w = CMP_W'(r_cmd.position);
    assign cnt_w = CMP_W'(r_count);
    assign full  = r_count == CNT_W'(DEPTH);

    // command decode
    always_comb begin
        n_count  = r_count;
        n_status = ST_IGNORED;
        n_found  = '0;
        n_rid    = '0;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        ins_pos  = r_count;
        unique case (r_cmd.command)
            CMD_ADD: begin
                if (seen_hit[DEPTH] || !r_cmd.has_key) begin
                    n_status = ST_IGNORED;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins   = 1'b1;
                    ins_pos  = seen_hig[DEPTH] ? CNT_W'(hig_pos) : r_count;
                    n_status = ST_DONE;
                end
            end
            CMD_REMOVE: begin
                if (seen_hit[DEPTH]) begin
                    do_rem   = 1'b1;
                    n_status = ST_DONE;
                end else begin
                    n_status = ST_MISS;
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins   = 1'b1;
                    ins_pos  = (pos_w > cnt_w) ? r_count : CNT_W'(r_cmd.position);
                    n_status = ST_DONE;
                end
            end
            CMD_FIND: begin
                if (seen_hit[DEPTH]) begin
                    n_found  = POS_FW'(hit_pos);
                    n_status = ST_DONE;
                end else begin
                    n_status = ST_MISS;
                end
            end
            CMD_READ: begin
                if (pos_w < cnt_w) begin
                    n_rid    = ID_FW'(read_sel);
                    n_status = ST_DONE;
                end else begin
                    n_status = ST_MISS;
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // per-slot moves: open a gap at the insert point, close one at the removal
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].capture = in_xfer;
            cell_ctrl[i].op      = OP_HOLD;
            if (do_upd && do_ins) begin
                if (CNT_W'(i) == ins_pos) begin
                    cell_ctrl[i].op = OP_LOAD;
                end else if (CNT_W'(i) > ins_pos) begin
                    cell_ctrl[i].op = OP_FROM_PREV;
                end
            end else if (do_upd && do_rem) begin
                if (IDX_W'(i) >= hit_pos) begin
                    cell_ctrl[i].op = OP_FROM_NEXT;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (do_upd) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_upd) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: hold the command and the per-command result fields
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= i_in_data;
        end
        if (do_upd) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_rid    <= n_rid;
        end
    end

    assign o_out_valid               = r_out_valid;
    assign o_out_data.status         = r_status;
    assign o_out_data.found_position = r_found;
    assign o_out_data.read_id        = r_rid;
    assign o_out_data.member_count   = COUNT_FW'(r_count);
    assign o_out_data.head_valid     = r_count != '0;
    assign o_out_data.head_id        = (r_count != '0) ? ID_FW'(cell_id[0]) : '0;

endmodule

// ----- rtl/pom_cell.sv -----
// One list slot: holds an id, its key and keyed flag, compares against the
// command bus and shifts to or from its neighbours. Depends on pom_pkg.
module pom_cell #(
    parameter int ID_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pom_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ID_BITS-1:0]        i_bus_id,
    input  logic [pom_pkg::KEY_W-1:0] i_bus_key,
    input  logic                      i_bus_keyed,
    input  logic [ID_BITS-1:0]        i_prev_id,
    input  logic [pom_pkg::KEY_W-1:0] i_prev_key,
    input  logic                      i_prev_keyed,
    input  logic [ID_BITS-1:0]        i_next_id,
    input  logic [pom_pkg::KEY_W-1:0] i_next_key,
    input  logic                      i_next_keyed,
    output logic [ID_BITS-1:0]        o_id,
    output logic [pom_pkg::KEY_W-1:0] o_key,
    output logic                      o_keyed,
    output pom_pkg::t_cell_flags      o_flags
);
    import pom_pkg::*;

    logic [ID_BITS-1:0] r_id,    n_id;
    logic [KEY_W-1:0]   r_key,   n_key;
    logic               r_keyed, n_keyed;
    t_cell_flags        r_flags, n_flags;

    always_comb begin
        n_id    = r_id;
        n_key   = r_key;
        n_keyed = r_keyed;
        unique case (i_ctrl.op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                n_id    = i_bus_id;
                n_key   = i_bus_key;
                n_keyed = i_bus_keyed;
            end
            OP_FROM_PREV: begin
                n_id    = i_prev_id;
                n_key   = i_prev_key;
                n_keyed = i_prev_keyed;
            end
            OP_FROM_NEXT: begin
                n_id    = i_next_id;
                n_key   = i_next_key;
                n_keyed = i_next_keyed;
            end
            default: begin
            end
        endcase
    end

    // snapshot the comparison when a command is taken in
    always_comb begin
        n_flags = r_flags;
        if (i_ctrl.capture) begin
            n_flags.match  = (r_id == i_bus_id);
            n_flags.higher = r_keyed && (i_bus_key > r_key);
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_key   <= n_key;
        r_keyed <= n_keyed;
        r_flags <= n_flags;
    end

    assign o_id    = r_id;
    assign o_key   = r_key;
    assign o_keyed = r_keyed;
    assign o_flags = r_flags;

    // reset is not needed: contents are only read below the fill count
    logic unused_rst;
    assign unused_rst = i_rst_n;

endmodule

// ----- rtl/pom_checker.sv -----
// Port-level checks for the priority-ordered member list, bound to the core.
// Depends on pom_pkg and priority_ordered_member_list_core.
module pom_checker #(
    parameter int DEPTH = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input pom_pkg::t_in_item  i_in_data,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input pom_pkg::t_out_item i_out_data
);
    import pom_pkg::*;

    logic unused_in;
    assign unused_in = i_in_valid ^ i_in_ready ^ (^i_in_data);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.head_valid == (i_out_data.member_count != '0)))
        else $error("head flag disagrees with member count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_out_data.member_count) <= DEPTH))
        else $error("member count beyond depth");

    a_clean_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != ST_DONE)
            |-> (i_out_data.read_id == '0) && (i_out_data.found_position == '0))
        else $error("lookup fields set on a failed command");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result transfer offered straight after reset");

endmodule

bind priority_ordered_member_list_core pom_checker #(
    .DEPTH (DEPTH)
) u_pom_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

// ----- tb/sv/testbench.sv -----
// Self-checking bench for priority_ordered_member_list_core: a queued driver,
// a reply checker fed by an in-bench list predictor, and random back-pressure.
// Depends on pom_pkg and the core top level only.
module testbench;

    import pom_pkg::*;

    localparam int LIST_DEPTH     = 16;
    localparam int LIST_ID_BITS   = 12;
    localparam int RUN_ITEMS      = 650;
    localparam int CALM_ITEMS     = 80;
    localparam int LOG_SIZE       = 4096;
    localparam int POOL_SIZE      = 20;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES  = 16;

    // Command codes with no function; the block answers them as ignored.
    localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    // One command waiting to be driven, with its pacing flags.
    typedef struct {
        t_in_item item;
        bit       drain;  // hold off until every reply so far has come back
        bit       calm;   // no idling from here on
    } t_pending;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      cmd_valid   = 1'b0;
    t_in_item  cmd_data    = '0;
    logic      reply_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_pending  cmd_queue[$];
    t_out_item predicted_reply[LOG_SIZE];
    int        accept_total    = 0;
    int        replies_checked = 0;
    int        error_count     = 0;
    int        quiet_cycles    = 0;
    bit        calm_phase      = 1'b0;

    // Predictor's copy of the list; entries at and above roster_len are
    // never read, so nothing needs clearing.
    logic [ID_FW-1:0]  roster_id    [LIST_DEPTH];
    logic [KEY_W-1:0]  roster_key   [LIST_DEPTH];
    logic              roster_keyed [LIST_DEPTH];
    int                roster_len = 0;

    logic [ID_FW-1:0]  id_pool [POOL_SIZE];

    priority_ordered_member_list_core #(
        .DEPTH   (LIST_DEPTH),
        .ID_BITS (LIST_ID_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (cmd_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (reply_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------

    // Open a gap at slot and write the new entry into it.
    task automatic roster_open(input int slot, input logic [ID_FW-1:0] id,
                               input logic [KEY_W-1:0] key, input logic keyed);
        int i;
        for (i = roster_len; i > slot; i--) begin
            roster_id[i]    = roster_id[i-1];
            roster_key[i]   = roster_key[i-1];
            roster_keyed[i] = roster_keyed[i-1];
        end
        roster_id[slot]    = id;
        roster_key[slot]   = key;
        roster_keyed[slot] = keyed;
        roster_len++;
    endtask

    // Apply one command to the predicted list and work out its reply.
    task automatic roster_apply(input t_in_item cmd, output t_out_item reply);
        int hit;
        int slot;
        int i;
        // Find and remove act on the first entry carrying the id.
        hit = -1;
        for (i = 0; i < roster_len; i++)
            if (hit < 0 && roster_id[i] == cmd.actor_id)
                hit = i;
        reply = '0;
        reply.status = ST_IGNORED;
        case (cmd.command)
            CMD_ADD: begin
                if (hit >= 0 || !cmd.has_key) begin
                    reply.status = ST_IGNORED;
                end else if (roster_len >= LIST_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    // In front of the first keyed entry with a strictly lower
                    // key; unkeyed entries take no part in the comparison.
                    slot = roster_len;
                    for (i = roster_len - 1; i >= 0; i--)
                        if (roster_keyed[i] && cmd.priority_key > roster_key[i])
                            slot = i;
                    roster_open(slot, cmd.actor_id, cmd.priority_key, cmd.has_key);
                    reply.status = ST_DONE;
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    for (i = hit; i + 1 < roster_len; i++) begin
                        roster_id[i]    = roster_id[i+1];
                        roster_key[i]   = roster_key[i+1];
                        roster_keyed[i] = roster_keyed[i+1];
                    end
                    roster_len--;
                    reply.status = ST_DONE;
                end else begin
                    reply.status = ST_MISS;
                end
            end
            CMD_INSERT: begin
                if (roster_len >= LIST_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    // Clamp the position to the count; duplicates are allowed.
                    slot = (int'(cmd.position) > roster_len) ? roster_len
                                                             : int'(cmd.position);
                    roster_open(slot, cmd.actor_id, cmd.priority_key, cmd.has_key);
                    reply.status = ST_DONE;
                end
            end
            CMD_FIND: begin
                if (hit >= 0) begin
                    reply.found_position = POS_FW'(hit);
                    reply.status = ST_DONE;
                end else begin
                    reply.status = ST_MISS;
                end
            end
            CMD_READ: begin
                if (int'(cmd.position) < roster_len) begin
                    reply.read_id = roster_id[cmd.position];
                    reply.status = ST_DONE;
                end else begin
                    reply.status = ST_MISS;
                end
            end
            default: reply.status = ST_IGNORED;
        endcase
        reply.member_count = COUNT_FW'(roster_len);
        reply.head_valid   = (roster_len > 0);
        reply.head_id      = (roster_len > 0) ? roster_id[0] : '0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_cmd(input logic [CMD_W-1:0] command, input int id, input int key,
                             input bit keyed, input int pos, input bit drain);
        t_pending p;
        p.item.command      = command;
        p.item.actor_id     = ID_FW'(id);
        p.item.priority_key = KEY_W'(key);
        p.item.has_key      = keyed;
        p.item.position     = POS_FW'(pos);
        p.drain             = drain;
        p.calm              = 1'b0;
        cmd_queue.push_back(p);
    endtask

    // Mostly ids from a small pool so that finds, removes and duplicates hit.
    function automatic int pick_id();
        if ($urandom_range(0, 3) != 0)
            return int'(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
        return $urandom_range(0, 4095);
    endfunction

    // Favour the extremes and a few repeated keys so that ties turn up.
    function automatic int pick_key();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 16'hFFFF;
            2, 3:    return 16'h0100 * $urandom_range(1, 3);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic bit field_differs(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: predict each transfer as it happens, then present
    // the next command or idle for a burst.
    // ------------------------------------------------------------------
    int gap_left = 0;
    int gap_pct  = 20;

    always @(posedge i_clk) begin : cmd_driver
        t_out_item reply;
        t_pending  nxt;
        int        taken;
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
            gap_left  <= 0;
        end else begin
            taken = accept_total;
            if (cmd_valid && o_in_ready) begin
                roster_apply(cmd_data, reply);
                predicted_reply[accept_total] = reply;
                accept_total <= accept_total + 1;
                taken++;
                // Re-pick the idling rate now and then; zero gives stretches
                // with no idling at all.
                if (taken % 50 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       gap_pct <= 0;
                        1:       gap_pct <= 10;
                        default: gap_pct <= 35;
                    endcase
                end
            end
            // The channel is free once the current command has transferred.
            if (!cmd_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left  <= gap_left - 1;
                    cmd_valid <= 1'b0;
                end else if (cmd_queue.size() == 0) begin
                    cmd_valid <= 1'b0;
                end else if (cmd_queue[0].drain && taken != replies_checked) begin
                    // Hold until every outstanding reply has been collected.
                    cmd_valid <= 1'b0;
                end else if (!cmd_queue[0].calm && $urandom_range(0, 99) < gap_pct) begin
                    gap_left  <= $urandom_range(0, 12);
                    cmd_valid <= 1'b0;
                end else begin
                    nxt = cmd_queue.pop_front();
                    cmd_data   <= nxt.item;
                    cmd_valid  <= 1'b1;
                    calm_phase <= nxt.calm;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reply side: random stall bursts on ready, independent of valid.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int stall_pct  = 20;

    always @(posedge i_clk) begin : reply_sink
        if (!i_rst_n) begin
            reply_ready <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            reply_ready <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 99) < stall_pct) begin
            stall_left  <= $urandom_range(0, 12);
            reply_ready <= 1'b0;
            stall_pct   <= (stall_pct == 0) ? 0 : $urandom_range(5, 40);
        end else begin
            reply_ready <= 1'b1;
            // Occasionally drop into a stretch with no stalls.
            if ($urandom_range(0, 99) == 0)
                stall_pct <= (stall_pct == 0) ? 25 : 0;
        end
    end

    // ------------------------------------------------------------------
    // Reply checker: compare each transfer with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : reply_check
        t_out_item want;
        bit        bad;
        if (i_rst_n && o_out_valid && reply_ready) begin
            if (replies_checked >= accept_total) begin
                $display("%0t: unexpected reply: expected none, actual %h", $time, o_out_data);
                error_count++;
            end else begin
                want = predicted_reply[replies_checked];
                bad  = field_differs("status", want.status, o_out_data.status)
                     | field_differs("found_position", want.found_position,
                                     o_out_data.found_position)
                     | field_differs("read_id", want.read_id, o_out_data.read_id)
                     | field_differs("member_count", want.member_count,
                                     o_out_data.member_count)
                     | field_differs("head_valid", want.head_valid, o_out_data.head_valid)
                     | field_differs("head_id", want.head_id, o_out_data.head_id);
                if (bad)
                    error_count++;
                replies_checked <= replies_checked + 1;
            end
        end
    end

    // Count cycles in which neither channel moves a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_valid && o_in_ready) || (o_out_valid && reply_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------
    initial begin : run_ctrl
        int  real_items;
        int  span;
        int  roll;
        int  i;
        bit  grow;
        logic [CMD_W-1:0] op;

        for (i = 0; i < POOL_SIZE; i++)
            id_pool[i] = ID_FW'($urandom_range(1, 4094));
        id_pool[0] = '0;
        id_pool[1] = 12'hFFF;

        // Directed: empty-list misses, both ignore cases for add, extremes,
        // equal keys, clamped and duplicate insert-at, unused codes.
        queue_cmd(CMD_READ,   0,     0,       1, 0,  0);
        queue_cmd(CMD_FIND,   0,     0,       1, 0,  0);
        queue_cmd(CMD_REMOVE, 4095,  0,       1, 0,  0);
        queue_cmd(CMD_ADD,    5,     16'h4000, 0, 0, 0);
        queue_cmd(CMD_ADD,    0,     0,       1, 0,  0);
        queue_cmd(CMD_ADD,    4095,  16'hFFFF, 1, 15, 0);
        queue_cmd(CMD_ADD,    0,     16'hFFFF, 1, 0, 0);
        queue_cmd(CMD_ADD,    100,   16'h0100, 1, 0, 0);
        queue_cmd(CMD_ADD,    101,   16'h0100, 1, 0, 0);
        queue_cmd(CMD_INSERT, 200,   16'hFFFF, 0, 15, 0);
        queue_cmd(CMD_ADD,    300,   16'h0080, 1, 0, 0);
        queue_cmd(CMD_INSERT, 100,   16'h8000, 1, 0,  0);
        queue_cmd(CMD_FIND,   100,   0,       1, 0,  0);
        queue_cmd(CMD_REMOVE, 100,   0,       1, 0,  0);
        queue_cmd(CMD_FIND,   100,   0,       1, 0,  0);
        queue_cmd(CMD_READ,   0,     0,       0, 15, 0);
        queue_cmd(CMD_READ,   0,     0,       0, 2,  0);
        queue_cmd(CMD_SPARE5, 77,    16'h1234, 1, 3, 0);
        queue_cmd(CMD_SPARE6, 77,    16'h1234, 1, 3, 0);
        queue_cmd(CMD_SPARE7, 4095,  16'hFFFF, 1, 15, 0);
        queue_cmd(CMD_FIND,   4095,  0,       1, 0,  0);
        queue_cmd(CMD_REMOVE, 0,     0,       1, 0,  0);

        // Random: alternate growing and shrinking episodes so the list keeps
        // running into full and empty; a sprinkle of unused codes on top.
        // Stop once the whole run holds RUN_ITEMS commands.
        real_items = 0;
        grow = 1'b1;
        while (cmd_queue.size() < RUN_ITEMS) begin
            span = $urandom_range(20, 60);
            repeat (span) begin
                if (cmd_queue.size() < RUN_ITEMS) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 4)
                        op = CMD_W'($urandom_range(int'(CMD_SPARE5), int'(CMD_SPARE7)));
                    else if (grow)
                        op = (roll < 49) ? CMD_ADD  : (roll < 67) ? CMD_INSERT :
                             (roll < 77) ? CMD_FIND : (roll < 87) ? CMD_READ : CMD_REMOVE;
                    else
                        op = (roll < 64) ? CMD_REMOVE : (roll < 69) ? CMD_ADD :
                             (roll < 72) ? CMD_INSERT : (roll < 84) ? CMD_FIND : CMD_READ;
                    // Drain while no real random command is queued yet and again once 300 are.
                    queue_cmd(op, pick_id(), pick_key(), ($urandom_range(0, 9) != 0),
                              $urandom_range(0, 15), (real_items == 0 || real_items == 300));
                    if (op <= CMD_READ)
                        real_items++;
                end
            end
            grow = !grow;
        end

        // No idling on either side for the tail of the run.
        for (i = cmd_queue.size() - CALM_ITEMS; i < cmd_queue.size(); i++)
            cmd_queue[i].calm = 1'b1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Poll away from the active edge so every update has settled.
        do
            @(negedge i_clk);
        while (cmd_queue.size() != 0 || cmd_valid || replies_checked != accept_total);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (error_count == 0 && replies_checked == accept_total)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
